// ----- hw/rtl/ttic_pkg.sv -----
// shared types and constants of the text to integer converter
`timescale 1ns / 1ps
package ttic_pkg;

    localparam int VALUE_BITS  = 32;
    localparam int COUNT_BITS  = 16;
    localparam int CHAR_BITS   = 8;
    localparam int BASE_BITS   = 6;
    localparam int PROD_BITS   = VALUE_BITS + BASE_BITS;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [BASE_BITS-1:0] BASE_AUTO = BASE_BITS'(0);
    localparam logic [BASE_BITS-1:0] BASE_MIN  = BASE_BITS'(2);
    localparam logic [BASE_BITS-1:0] BASE_OCT  = BASE_BITS'(8);
    localparam logic [BASE_BITS-1:0] BASE_DEC  = BASE_BITS'(10);
    localparam logic [BASE_BITS-1:0] BASE_HEX  = BASE_BITS'(16);
    localparam logic [BASE_BITS-1:0] BASE_MAX  = BASE_BITS'(36);
    localparam logic [BASE_BITS-1:0] ALPHA_OFS = BASE_BITS'(10);

    localparam logic [CHAR_BITS-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_BITS-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_BITS-1:0] CH_LF    = 8'h0a;
    localparam logic [CHAR_BITS-1:0] CH_VT    = 8'h0b;
    localparam logic [CHAR_BITS-1:0] CH_FF    = 8'h0c;
    localparam logic [CHAR_BITS-1:0] CH_CR    = 8'h0d;
    localparam logic [CHAR_BITS-1:0] CH_PLUS  = 8'h2b;
    localparam logic [CHAR_BITS-1:0] CH_MINUS = 8'h2d;
    localparam logic [CHAR_BITS-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_BITS-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_BITS-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_BITS-1:0] CH_UX    = 8'h58;
    localparam logic [CHAR_BITS-1:0] CH_UZ    = 8'h5a;
    localparam logic [CHAR_BITS-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_BITS-1:0] CH_LX    = 8'h78;
    localparam logic [CHAR_BITS-1:0] CH_LZ    = 8'h7a;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NODIG   = 2'd1,
        ST_OVF     = 2'd2,
        ST_BADBASE = 2'd3
    } status_t;

    typedef struct packed {
        logic [CHAR_BITS-1:0] ch;
        logic                 start_req;
        logic [BASE_BITS-1:0] radix;
        logic                 unsigned_mode;
    } char_item_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic [COUNT_BITS-1:0] consumed;
        status_t               status;
    } result_item_t;

    // classified character handed from front to back
    typedef struct packed {
        logic                 start;
        logic                 bad_base;
        logic [BASE_BITS-1:0] radix;
        logic                 unsigned_mode;
        logic                 is_space;
        logic                 is_plus;
        logic                 is_minus;
        logic                 is_zero;
        logic                 is_x;
        logic                 digit_ok;
        logic [BASE_BITS-1:0] digit;
    } cls_item_t;

endpackage

// ----- hw/rtl/ttic_front.sv -----
// front end: accepts characters and classifies them
`timescale 1ns / 1ps
module ttic_front
(
    input  logic                  char_valid,
    output logic                  char_ready,
    input  ttic_pkg::char_item_t  char_item,
    output logic                  cls_valid,
    input  logic                  cls_ready,
    output ttic_pkg::cls_item_t   cls_item
);

    logic [ttic_pkg::CHAR_BITS-1:0] c;

    assign c          = char_item.ch;
    assign cls_valid  = char_valid;
    assign char_ready = cls_ready;

    always_comb
    begin
        cls_item               = '0;
        cls_item.start         = char_item.start_req;
        cls_item.radix         = char_item.radix;
        cls_item.unsigned_mode = char_item.unsigned_mode;
        cls_item.bad_base      = (char_item.radix != ttic_pkg::BASE_AUTO) &&
                                 ((char_item.radix < ttic_pkg::BASE_MIN) ||
                                  (char_item.radix > ttic_pkg::BASE_MAX));
        cls_item.is_space      = (c == ttic_pkg::CH_SPACE) || (c == ttic_pkg::CH_TAB) ||
                                 (c == ttic_pkg::CH_LF) || (c == ttic_pkg::CH_VT) ||
                                 (c == ttic_pkg::CH_FF) || (c == ttic_pkg::CH_CR);
        cls_item.is_plus       = (c == ttic_pkg::CH_PLUS);
        cls_item.is_minus      = (c == ttic_pkg::CH_MINUS);
        cls_item.is_zero       = (c == ttic_pkg::CH_0);
        cls_item.is_x          = (c == ttic_pkg::CH_LX) || (c == ttic_pkg::CH_UX);
        if ((c >= ttic_pkg::CH_0) && (c <= ttic_pkg::CH_9))
        begin
            cls_item.digit_ok = 1'b1;
            cls_item.digit    = ttic_pkg::BASE_BITS'(c - ttic_pkg::CH_0);
        end
        else if ((c >= ttic_pkg::CH_LA) && (c <= ttic_pkg::CH_LZ))
        begin
            cls_item.digit_ok = 1'b1;
            cls_item.digit    = ttic_pkg::BASE_BITS'(c - ttic_pkg::CH_LA) + ttic_pkg::ALPHA_OFS;
        end
        else if ((c >= ttic_pkg::CH_UA) && (c <= ttic_pkg::CH_UZ))
        begin
            cls_item.digit_ok = 1'b1;
            cls_item.digit    = ttic_pkg::BASE_BITS'(c - ttic_pkg::CH_UA) + ttic_pkg::ALPHA_OFS;
        end
    end

endmodule

// ----- hw/rtl/ttic_queue.sv -----
// short fifo of classified characters between front and back
`timescale 1ns / 1ps
module ttic_queue
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  ttic_pkg::cls_item_t  push_item,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output ttic_pkg::cls_item_t  pop_item
);

    ttic_pkg::cls_item_t               entry_reg [ttic_pkg::QUEUE_DEPTH];
    logic [ttic_pkg::QPTR_BITS-1:0]    wr_ptr_reg;
    logic [ttic_pkg::QPTR_BITS-1:0]    rd_ptr_reg;
    logic [ttic_pkg::QCNT_BITS-1:0]    count_reg;
    logic [ttic_pkg::QCNT_BITS-1:0]    count_next;
    logic                              do_push;
    logic                              do_pop;

    assign push_ready = (count_reg < ttic_pkg::QCNT_BITS'(ttic_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == ttic_pkg::QPTR_BITS'(ttic_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == ttic_pkg::QPTR_BITS'(ttic_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- hw/rtl/ttic_back.sv -----
// back end: conversion state machine, digit accumulate and result register
`timescale 1ns / 1ps
module ttic_back
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cls_valid,
    output logic                    cls_ready,
    input  ttic_pkg::cls_item_t     cls_item,
    output logic                    res_valid,
    input  logic                    res_ready,
    output ttic_pkg::result_item_t  res_item
);

    localparam int VB = ttic_pkg::VALUE_BITS;
    localparam int CB = ttic_pkg::COUNT_BITS;
    localparam int BB = ttic_pkg::BASE_BITS;
    localparam int PB = ttic_pkg::PROD_BITS;
    localparam logic [VB-1:0] VAL_TOP = {1'b1, {(VB-1){1'b0}}};
    localparam logic [VB-1:0] VAL_POS = ~VAL_TOP;
    localparam logic [VB-1:0] VAL_ALL = '1;
    localparam logic [CB-1:0] CNT_MAX = '1;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEAD,
        PH_SIGNED,
        PH_ZERO,
        PH_ZERO_X,
        PH_DIGITS
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [BB-1:0]          base_reg, base_next;
    logic                   neg_reg, neg_next;
    logic                   uns_reg, uns_next;
    logic [VB-1:0]          acc_reg, acc_next;
    logic                   ovf_reg, ovf_next;
    logic                   any_reg, any_next;
    logic [CB-1:0]          idx_reg, idx_next;
    logic [CB-1:0]          pze_reg, pze_next;
    logic                   res_valid_reg, res_valid_next;
    ttic_pkg::result_item_t res_item_reg, res_item_next;

    logic                   fire;
    logic                   emit;
    logic                   do_first;
    logic                   do_take;
    logic [PB-1:0]          prod;
    logic [PB-1:0]          limit;
    ttic_pkg::result_item_t emit_item;

    function automatic logic [CB-1:0] cnt_inc(input logic [CB-1:0] c);
        return (c == CNT_MAX) ? c : c + 1'b1;
    endfunction

    assign cls_ready = !res_valid_reg || res_ready;
    assign fire      = cls_valid && cls_ready;
    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

    always_comb
    begin
        phase_next = phase_reg;
        base_next  = base_reg;
        neg_next   = neg_reg;
        uns_next   = uns_reg;
        acc_next   = acc_reg;
        ovf_next   = ovf_reg;
        any_next   = any_reg;
        idx_next   = idx_reg;
        pze_next   = pze_reg;
        emit       = 1'b0;
        emit_item  = '0;
        do_first   = 1'b0;
        do_take    = 1'b0;
        prod       = '0;
        limit      = '0;

        if (cls_item.start)
        begin
            base_next  = cls_item.radix;
            neg_next   = 1'b0;
            uns_next   = cls_item.unsigned_mode;
            acc_next   = '0;
            ovf_next   = 1'b0;
            any_next   = 1'b0;
            idx_next   = '0;
            pze_next   = '0;
            phase_next = PH_LEAD;
        end

        if (cls_item.start && cls_item.bad_base)
        begin
            emit             = 1'b1;
            emit_item.status = ttic_pkg::ST_BADBASE;
        end
        else
        begin
            case (phase_next)
                PH_LEAD:
                begin
                    if (cls_item.is_space)
                    begin
                        idx_next = cnt_inc(idx_next);
                    end
                    else if (cls_item.is_plus || cls_item.is_minus)
                    begin
                        neg_next   = cls_item.is_minus;
                        idx_next   = cnt_inc(idx_next);
                        phase_next = PH_SIGNED;
                    end
                    else
                    begin
                        do_first = 1'b1;
                    end
                end
                PH_SIGNED:
                begin
                    do_first = 1'b1;
                end
                PH_ZERO:
                begin
                    if (cls_item.is_x)
                    begin
                        idx_next   = cnt_inc(idx_next);
                        phase_next = PH_ZERO_X;
                    end
                    else
                    begin
                        if (base_next == ttic_pkg::BASE_AUTO)
                        begin
                            base_next = ttic_pkg::BASE_OCT;
                        end
                        do_take = 1'b1;
                    end
                end
                PH_ZERO_X:
                begin
                    if (cls_item.digit_ok && (cls_item.digit < ttic_pkg::BASE_HEX))
                    begin
                        base_next = ttic_pkg::BASE_HEX;
                        do_take   = 1'b1;
                    end
                    else
                    begin
                        emit               = 1'b1;
                        emit_item.consumed = pze_next;
                        emit_item.status   = ttic_pkg::ST_OK;
                    end
                end
                PH_DIGITS:
                begin
                    do_take = 1'b1;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase

            // first char: a zero may open a hex prefix, else base is set
            if (do_first)
            begin
                if (cls_item.is_zero &&
                    ((base_next == ttic_pkg::BASE_AUTO) || (base_next == ttic_pkg::BASE_HEX)))
                begin
                    any_next   = 1'b1;
                    idx_next   = cnt_inc(idx_next);
                    pze_next   = idx_next;
                    phase_next = PH_ZERO;
                end
                else
                begin
                    if (base_next == ttic_pkg::BASE_AUTO)
                    begin
                        base_next = ttic_pkg::BASE_DEC;
                    end
                    do_take = 1'b1;
                end
            end

            if (do_take)
            begin
                phase_next = PH_DIGITS;
                if (cls_item.digit_ok && (cls_item.digit < base_next))
                begin
                    any_next = 1'b1;
                    limit    = PB'(uns_next ? VAL_ALL : (neg_next ? VAL_TOP : VAL_POS));
                    prod     = PB'(acc_next) * PB'(base_next) + PB'(cls_item.digit);
                    if (prod > limit)
                    begin
                        ovf_next = 1'b1;
                    end
                    else if (!ovf_next)
                    begin
                        acc_next = prod[VB-1:0];
                    end
                    idx_next = cnt_inc(idx_next);
                end
                else
                begin
                    emit = 1'b1;
                    if (!any_next)
                    begin
                        emit_item.status = ttic_pkg::ST_NODIG;
                    end
                    else if (ovf_next)
                    begin
                        emit_item.value    = uns_next ? VAL_ALL : (neg_next ? VAL_TOP : VAL_POS);
                        emit_item.consumed = idx_next;
                        emit_item.status   = ttic_pkg::ST_OVF;
                    end
                    else
                    begin
                        emit_item.value    = neg_next ? (VB'(0) - acc_next) : acc_next;
                        emit_item.consumed = idx_next;
                        emit_item.status   = ttic_pkg::ST_OK;
                    end
                end
            end
        end

        if (emit)
        begin
            phase_next = PH_IDLE;
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg && !res_ready;
        res_item_next  = res_item_reg;
        if (fire && emit)
        begin
            res_valid_next = 1'b1;
            res_item_next  = emit_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            base_reg      <= '0;
            neg_reg       <= 1'b0;
            uns_reg       <= 1'b0;
            acc_reg       <= '0;
            ovf_reg       <= 1'b0;
            any_reg       <= 1'b0;
            idx_reg       <= '0;
            pze_reg       <= '0;
            res_valid_reg <= 1'b0;
            res_item_reg  <= '0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            res_item_reg  <= res_item_next;
            if (fire)
            begin
                phase_reg <= phase_next;
                base_reg  <= base_next;
                neg_reg   <= neg_next;
                uns_reg   <= uns_next;
                acc_reg   <= acc_next;
                ovf_reg   <= ovf_next;
                any_reg   <= any_next;
                idx_reg   <= idx_next;
                pze_reg   <= pze_next;
            end
        end
    end

endmodule

// ----- hw/rtl/text_to_integer_converter_core.sv -----
// top level of the streaming text to integer converter
//
//  channel  direction  handshake                payload
//  char     in         char_valid / char_ready  char_item  (ch, start_req, radix, unsigned_mode)
//  res      out        res_valid / res_ready    res_item   (value, consumed, status)
//
// one character per cycle while results are taken; the back end does one multiply-add
// and limit compare per character; an ending character is queued, then its result registered
// the front and back are parted by a 2-entry queue, the result sits in an output register
// rst_n clears the queue, the conversion state and the output register at once
// a stalled result holds the back end; characters still enter until the queue fills
`timescale 1ns / 1ps
module text_to_integer_converter_core
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    char_valid,
    output logic                    char_ready,
    input  ttic_pkg::char_item_t    char_item,
    output logic                    res_valid,
    input  logic                    res_ready,
    output ttic_pkg::result_item_t  res_item
);

    logic                 f_valid;
    logic                 f_ready;
    ttic_pkg::cls_item_t  f_item;
    logic                 q_valid;
    logic                 q_ready;
    ttic_pkg::cls_item_t  q_item;

    ttic_front u_front
    (
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_item  (char_item),
        .cls_valid  (f_valid),
        .cls_ready  (f_ready),
        .cls_item   (f_item)
    );

    ttic_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_item  (f_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_item   (q_item)
    );

    ttic_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cls_valid  (q_valid),
        .cls_ready  (q_ready),
        .cls_item   (q_item),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_item   (res_item)
    );

    a_badbase_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_item.status == ttic_pkg::ST_BADBASE) |->
        (res_item.value == '0) && (res_item.consumed == '0))
        else $error("invalid base result not zero");

    a_nodig_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_item.status == ttic_pkg::ST_NODIG) |->
        (res_item.value == '0) && (res_item.consumed == '0))
        else $error("no digits result not zero");

    a_ovf_consumed: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_item.status == ttic_pkg::ST_OVF) |-> (res_item.consumed != '0))
        else $error("overflow result with nothing consumed");

    a_res_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid ##1 res_valid |-> $past(q_valid && q_ready))
        else $error("result without a taken item");

endmodule

// ----- tb/testbench.sv -----
// self-checking testbench of the streaming text to integer converter
`timescale 1ns / 1ps
module testbench;

    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_CHARS  = 130;
    localparam int DRAIN_CYCLES = 20;
    localparam int CB = ttic_pkg::CHAR_BITS;
    localparam int BB = ttic_pkg::BASE_BITS;
    localparam int VB = ttic_pkg::VALUE_BITS;
    localparam int NB = ttic_pkg::COUNT_BITS;
    localparam logic [CB-1:0] CH_NUL = 8'h00;

    class strtol_checker;
        typedef enum logic [2:0] {
            CP_IDLE,
            CP_LEAD,
            CP_SIGN,
            CP_ZERO,
            CP_ZERO_X,
            CP_DIGITS
        } conv_phase_t;

        conv_phase_t     conv_ph = CP_IDLE;
        logic [BB-1:0]   base_r = '0;
        bit              negative = 0;
        bit              unsigned_conv = 0;
        longint unsigned acc = 0;
        bit              overflow_seen = 0;
        bit              digit_seen = 0;
        logic [NB-1:0]   char_count = '0;
        logic [NB-1:0]   zero_end = '0;

        ttic_pkg::result_item_t expected_results[$];
        int errors = 0;
        int checked = 0;
        int live_chars = 0;
        int status_seen[4] = '{0, 0, 0, 0};

        task report(string msg);
            errors++;
            if (errors <= 100)
                $display("%0t mismatch: %s", $time, msg);
        endtask

        function void push_result(logic [VB-1:0] v, logic [NB-1:0] n,
                                  ttic_pkg::status_t st);
            ttic_pkg::result_item_t r;
            r.value = v;
            r.consumed = n;
            r.status = st;
            expected_results.push_back(r);
            conv_ph = CP_IDLE;
        endfunction

        function logic [NB-1:0] count_up(logic [NB-1:0] c);
            return (c == '1) ? c : c + 1'b1;
        endfunction

        function int char_to_digit(logic [CB-1:0] c);
            if (c >= ttic_pkg::CH_0 && c <= ttic_pkg::CH_9)
                return int'(c - ttic_pkg::CH_0);
            if (c >= ttic_pkg::CH_LA && c <= ttic_pkg::CH_LZ)
                return int'(c - ttic_pkg::CH_LA) + 10;
            if (c >= ttic_pkg::CH_UA && c <= ttic_pkg::CH_UZ)
                return int'(c - ttic_pkg::CH_UA) + 10;
            return 99;
        endfunction

        function bit is_blank(logic [CB-1:0] c);
            return c == ttic_pkg::CH_SPACE || c == ttic_pkg::CH_TAB || c == ttic_pkg::CH_LF ||
                   c == ttic_pkg::CH_CR || c == ttic_pkg::CH_FF || c == ttic_pkg::CH_VT;
        endfunction

        function void close_number();
            logic [VB-1:0] v;
            if (!digit_seen)
            begin
                push_result('0, '0, ttic_pkg::ST_NODIG);
            end
            else if (overflow_seen)
            begin
                if (unsigned_conv)
                    v = 32'hffff_ffff;
                else
                    v = negative ? 32'h8000_0000 : 32'h7fff_ffff;
                push_result(v, char_count, ttic_pkg::ST_OVF);
            end
            else
            begin
                v = acc[VB-1:0];
                if (negative)
                    v = -v;
                push_result(v, char_count, ttic_pkg::ST_OK);
            end
        endfunction

        function void accumulate_digit(logic [CB-1:0] c);
            int d;
            longint unsigned lim;
            longint unsigned cutoff;
            longint unsigned cutlim;
            d = char_to_digit(c);
            conv_ph = CP_DIGITS;
            if (base_r < ttic_pkg::BASE_MIN || d >= int'(base_r))
            begin
                close_number();
                return;
            end
            digit_seen = 1;
            if (unsigned_conv)
                lim = 64'hffff_ffff;
            else
                lim = negative ? 64'h8000_0000 : 64'h7fff_ffff;
            cutoff = lim / base_r;
            cutlim = lim % base_r;
            if (acc > cutoff || (acc == cutoff && longint'(d) > cutlim))
                overflow_seen = 1;
            else if (!overflow_seen)
                acc = acc * base_r + longint'(d);
            char_count = count_up(char_count);
        endfunction

        function void lead_digit(logic [CB-1:0] c);
            if (c == ttic_pkg::CH_0 &&
                (base_r == ttic_pkg::BASE_AUTO || base_r == ttic_pkg::BASE_HEX))
            begin
                digit_seen = 1;
                char_count = count_up(char_count);
                zero_end = char_count;
                conv_ph = CP_ZERO;
            end
            else
            begin
                if (base_r == ttic_pkg::BASE_AUTO)
                    base_r = ttic_pkg::BASE_DEC;
                accumulate_digit(c);
            end
        endfunction

        function void take_char(ttic_pkg::char_item_t it);
            logic [CB-1:0] c;
            int d;
            c = it.ch;
            // a plain item while idle is dropped by the block
            if (!it.start_req && conv_ph == CP_IDLE)
                return;
            live_chars++;
            if (it.start_req)
            begin
                base_r = '0;
                negative = 0;
                acc = 0;
                overflow_seen = 0;
                digit_seen = 0;
                char_count = '0;
                zero_end = '0;
                unsigned_conv = it.unsigned_mode;
                conv_ph = CP_IDLE;
                if (it.radix != ttic_pkg::BASE_AUTO &&
                    (it.radix < ttic_pkg::BASE_MIN || it.radix > ttic_pkg::BASE_MAX))
                begin
                    push_result('0, '0, ttic_pkg::ST_BADBASE);
                    return;
                end
                base_r = it.radix;
                conv_ph = CP_LEAD;
            end
            case (conv_ph)
                CP_LEAD:
                begin
                    if (is_blank(c))
                    begin
                        char_count = count_up(char_count);
                    end
                    else if (c == ttic_pkg::CH_MINUS || c == ttic_pkg::CH_PLUS)
                    begin
                        negative = (c == ttic_pkg::CH_MINUS);
                        char_count = count_up(char_count);
                        conv_ph = CP_SIGN;
                    end
                    else
                    begin
                        lead_digit(c);
                    end
                end
                CP_SIGN:
                    lead_digit(c);
                CP_ZERO:
                begin
                    if (c == ttic_pkg::CH_LX || c == ttic_pkg::CH_UX)
                    begin
                        char_count = count_up(char_count);
                        conv_ph = CP_ZERO_X;
                    end
                    else
                    begin
                        if (base_r == ttic_pkg::BASE_AUTO)
                            base_r = ttic_pkg::BASE_OCT;
                        accumulate_digit(c);
                    end
                end
                CP_ZERO_X:
                begin
                    d = char_to_digit(c);
                    if (d < 16)
                    begin
                        base_r = ttic_pkg::BASE_HEX;
                        accumulate_digit(c);
                    end
                    else
                    begin
                        // bare prefix, only the zero counts
                        push_result('0, zero_end, ttic_pkg::ST_OK);
                    end
                end
                CP_DIGITS:
                    accumulate_digit(c);
                default:
                    conv_ph = CP_IDLE;
            endcase
        endfunction

        task check_result(ttic_pkg::result_item_t got);
            ttic_pkg::result_item_t want;
            checked++;
            status_seen[got.status]++;
            if (expected_results.size() == 0)
            begin
                report($sformatf("result with none expected: value %h consumed %0d status %0d",
                                 got.value, got.consumed, got.status));
                return;
            end
            want = expected_results.pop_front();
            if (got.value !== want.value)
                report($sformatf("value %h, expected %h", got.value, want.value));
            if (got.consumed !== want.consumed)
                report($sformatf("consumed %0d, expected %0d", got.consumed, want.consumed));
            if (got.status !== want.status)
                report($sformatf("status %0d, expected %0d", got.status, want.status));
        endtask
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   char_valid;
    logic                   char_ready;
    ttic_pkg::char_item_t   char_item;
    logic                   res_valid;
    logic                   res_ready;
    ttic_pkg::result_item_t res_item;

    strtol_checker chk = new;

    int  sender_idle_pct = 0;
    int  stall_pct = 0;
    bit  hold_req = 0;
    bit  hold_done = 0;
    int  hold_left = 0;
    int  idle_cycles = 0;
    bit  running = 0;
    logic [CB-1:0] text_q[$];

    text_to_integer_converter_core dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_item  (char_item),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_item   (res_item)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result side, long hold-off counted here
    always @(negedge clk)
    begin
        if (hold_req && !hold_done)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES - 1;
            res_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            res_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
        begin
            res_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (running)
        begin
            if (res_valid && res_ready)
                chk.check_result(res_item);
            if ((char_valid && char_ready) || (res_valid && res_ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
                if (idle_cycles >= STALL_LIMIT)
                begin
                    $display("watchdog: nothing moved for %0d cycles", STALL_LIMIT);
                    $display("testbench: FAIL");
                    $finish;
                end
            end
        end
    end

    task send_item(input logic [CB-1:0] ch, input bit st,
                   input logic [BB-1:0] radix, input bit uns);
        ttic_pkg::char_item_t it;
        while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct)
        begin
            char_valid <= 1'b0;
            @(negedge clk);
        end
        it.ch = ch;
        it.start_req = st;
        it.radix = radix;
        it.unsigned_mode = uns;
        char_valid <= 1'b1;
        char_item <= it;
        do
            @(posedge clk);
        while (!char_ready);
        chk.take_char(it);
        @(negedge clk);
    endtask

    task add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endtask

    // first queued char carries the start
    task convert(input logic [BB-1:0] radix, input bit uns);
        for (int i = 0; i < text_q.size(); i++)
        begin
            if (i == 0)
                send_item(text_q[i], 1'b1, radix, uns);
            else
                send_item(text_q[i], 1'b0, BB'($urandom_range(63)), 1'($urandom_range(1)));
        end
        text_q.delete();
    endtask

    task run_text(input string s, input logic [CB-1:0] term,
                  input logic [BB-1:0] radix, input bit uns);
        add_text(s);
        text_q.push_back(term);
        convert(radix, uns);
    endtask

    task wait_for_results();
        char_valid <= 1'b0;
        while (chk.expected_results.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    function logic [CB-1:0] blank_char(int k);
        case (k)
            0: return ttic_pkg::CH_SPACE;
            1: return ttic_pkg::CH_TAB;
            2: return ttic_pkg::CH_LF;
            3: return ttic_pkg::CH_VT;
            4: return ttic_pkg::CH_FF;
            default: return ttic_pkg::CH_CR;
        endcase
    endfunction

    function logic [CB-1:0] digit_char(int d);
        if (d < 10)
            return CB'(int'(ttic_pkg::CH_0) + d);
        return CB'(int'($urandom_range(1) ? ttic_pkg::CH_UA : ttic_pkg::CH_LA) + d - 10);
    endfunction

    task rand_conversion();
        int kind;
        int r;
        int b;
        int p;
        int nd;
        logic [BB-1:0] radix;
        bit uns;
        kind = $urandom_range(99);
        uns = 1'($urandom_range(1));
        if (kind < 6)
        begin
            repeat ($urandom_range(1, 6))
                text_q.push_back(CB'($urandom_range(255)));
            convert(BB'($urandom_range(63)), uns);
            return;
        end
        if (kind < 10)
        begin
            repeat ($urandom_range(1, 3))
                send_item(CB'($urandom_range(255)), 1'b0, BB'($urandom_range(63)),
                          1'($urandom_range(1)));
            return;
        end
        r = $urandom_range(99);
        if (r < 15)
            radix = ttic_pkg::BASE_AUTO;
        else if (r < 30)
            radix = ttic_pkg::BASE_DEC;
        else if (r < 42)
            radix = ttic_pkg::BASE_HEX;
        else if (r < 50)
            radix = ttic_pkg::BASE_OCT;
        else if (r < 56)
            radix = ttic_pkg::BASE_MIN;
        else if (r < 62)
            radix = ttic_pkg::BASE_MAX;
        else if (r < 92)
            radix = BB'($urandom_range(ttic_pkg::BASE_MIN, ttic_pkg::BASE_MAX));
        else if (r < 95)
            radix = ttic_pkg::BASE_MIN - 1'b1;
        else
            radix = BB'($urandom_range(int'(ttic_pkg::BASE_MAX) + 1, 63));
        b = (radix >= ttic_pkg::BASE_MIN && radix <= ttic_pkg::BASE_MAX) ? int'(radix) : 10;
        repeat ($urandom_range(0, 2))
            text_q.push_back(blank_char($urandom_range(5)));
        p = $urandom_range(2);
        if (p == 1)
            text_q.push_back(ttic_pkg::CH_PLUS);
        else if (p == 2)
            text_q.push_back(ttic_pkg::CH_MINUS);
        if (radix == ttic_pkg::BASE_AUTO || radix == ttic_pkg::BASE_HEX)
        begin
            p = $urandom_range(5);
            if (p < 2)
            begin
                text_q.push_back(ttic_pkg::CH_0);
                text_q.push_back(p == 0 ? ttic_pkg::CH_LX : ttic_pkg::CH_UX);
                b = 16;
            end
            else if (p == 2)
            begin
                text_q.push_back(ttic_pkg::CH_0);
                b = (radix == ttic_pkg::BASE_AUTO) ? 8 : 16;
            end
        end
        nd = ($urandom_range(9) == 0) ? $urandom_range(11, 34) : $urandom_range(0, 8);
        repeat (nd)
            text_q.push_back(digit_char($urandom_range(b - 1)));
        p = $urandom_range(9);
        if (p < 6)
            text_q.push_back(CH_NUL);
        else if (p < 9)
            text_q.push_back(CB'($urandom_range(255)));
        convert(radix, uns);
    endtask

    initial
    begin
        rst_n = 1'b0;
        char_valid = 1'b0;
        char_item = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        running = 1;

        run_text("  -123", CH_NUL, ttic_pkg::BASE_DEC, 1'b0);
        text_q.push_back(ttic_pkg::CH_TAB);
        text_q.push_back(ttic_pkg::CH_LF);
        text_q.push_back(ttic_pkg::CH_VT);
        text_q.push_back(ttic_pkg::CH_FF);
        text_q.push_back(ttic_pkg::CH_CR);
        text_q.push_back(ttic_pkg::CH_SPACE);
        run_text("+42", 8'h3b, ttic_pkg::BASE_AUTO, 1'b0);
        run_text("0x1F", CH_NUL, ttic_pkg::BASE_AUTO, 1'b0);
        run_text("0X7fffffff", CH_NUL, ttic_pkg::BASE_HEX, 1'b0);
        run_text("0xg", CH_NUL, ttic_pkg::BASE_HEX, 1'b0);
        run_text("0x", CH_NUL, ttic_pkg::BASE_AUTO, 1'b1);
        run_text("0777", CH_NUL, ttic_pkg::BASE_AUTO, 1'b0);
        run_text("089", CH_NUL, ttic_pkg::BASE_AUTO, 1'b0);
        run_text("2147483647", CH_NUL, ttic_pkg::BASE_DEC, 1'b0);
        run_text("2147483648", CH_NUL, ttic_pkg::BASE_DEC, 1'b0);
        run_text("-2147483648", CH_NUL, ttic_pkg::BASE_DEC, 1'b0);
        run_text("-2147483649", CH_NUL, ttic_pkg::BASE_DEC, 1'b0);
        run_text("4294967295", CH_NUL, ttic_pkg::BASE_DEC, 1'b1);
        run_text("4294967296", CH_NUL, ttic_pkg::BASE_DEC, 1'b1);
        run_text("-1", CH_NUL, ttic_pkg::BASE_DEC, 1'b1);
        run_text("-4294967296", CH_NUL, ttic_pkg::BASE_DEC, 1'b1);
        run_text("zZ", 8'hff, ttic_pkg::BASE_MAX, 1'b0);
        run_text("1012", CH_NUL, ttic_pkg::BASE_MIN, 1'b0);
        run_text("7", CH_NUL, ttic_pkg::BASE_MIN - 1'b1, 1'b0);
        run_text("7", CH_NUL, ttic_pkg::BASE_MAX + 1'b1, 1'b1);
        run_text("7", CH_NUL, 6'h3f, 1'b0);
        run_text("   ", CH_NUL, ttic_pkg::BASE_DEC, 1'b0);
        run_text("-", CH_NUL, ttic_pkg::BASE_AUTO, 1'b0);
        run_text("+x", CH_NUL, ttic_pkg::BASE_HEX, 1'b1);
        // plain items while idle, then a restart in mid-number
        send_item(8'h31, 1'b0, 6'h3f, 1'b1);
        send_item(CH_NUL, 1'b0, ttic_pkg::BASE_AUTO, 1'b0);
        add_text("123");
        convert(ttic_pkg::BASE_DEC, 1'b0);
        run_text("7", CH_NUL, ttic_pkg::BASE_DEC, 1'b0);
        wait_for_results();

        for (int ph = 0; ph < 4; ph++)
        begin
            int first_live;
            int nconv;
            case (ph)
                0:
                begin
                    sender_idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct = 67;
                    stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct = 0;
                    stall_pct = 67;
                end
                default:
                begin
                    sender_idle_pct = 35;
                    stall_pct = 35;
                end
            endcase
            first_live = chk.live_chars;
            nconv = 0;
            while (chk.live_chars - first_live < PHASE_CHARS)
            begin
                if (ph == 0 && nconv == 10)
                    hold_req = 1'b1;
                rand_conversion();
                nconv++;
            end
            send_item(CH_NUL, 1'b0, ttic_pkg::BASE_AUTO, 1'b0);
            wait_for_results();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (chk.expected_results.size() != 0)
            chk.report($sformatf("%0d results never arrived", chk.expected_results.size()));
        $display("run: %0d chars used, %0d results checked, %0d mismatches",
                 chk.live_chars, chk.checked, chk.errors);
        $display("status mix: ok %0d, no digits %0d, overflow %0d, bad base %0d",
                 chk.status_seen[0], chk.status_seen[1], chk.status_seen[2],
                 chk.status_seen[3]);
        if (chk.errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end
endmodule
